### rtl/core/kms_pkg.sv
// kms_pkg: shared types and constants of the keyboard matrix scanner
// operation codes, interrupt codes, row limits and the transaction structs
// no dependencies
package kms_pkg;

	localparam int MaxRows    = 16;
	localparam int DefRows    = 12;
	localparam int MaskW      = 12;
	localparam int ColW       = 16;
	localparam int RowW       = 4;
	localparam int RsiLastRow = 8;

	localparam logic [ColW-1:0] OnBit   = 16'h8000;
	localparam logic [ColW-1:0] OnClear = 16'h7FFF;

	localparam logic [2:0] OP_SCAN    = 3'd0;
	localparam logic [2:0] OP_IRQ_RST = 3'd1;
	localparam logic [2:0] OP_PRESS   = 3'd2;
	localparam logic [2:0] OP_RELEASE = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	localparam logic [1:0] IRQ_NONE     = 2'd0;
	localparam logic [1:0] IRQ_MASKABLE = 2'd1;
	localparam logic [1:0] IRQ_NMI      = 2'd2;

	typedef struct packed {
		logic [2:0]       op;
		logic [MaskW-1:0] out_mask;
		logic [RowW-1:0]  row;
		logic [ColW-1:0]  col_mask;
		logic             on_key;
	} kms_in_t;

	typedef struct packed {
		logic [ColW-1:0] in_value;
		logic [1:0]      irq_request;
		logic            bad_row;
	} kms_out_t;

endpackage

### rtl/core/kms_row_file.sv
// kms_row_file: column word register per keyboard row, with scan and update
// computes the result of one operation and updates the rows when it retires
// depends on kms_pkg
module kms_row_file #(
	parameter int ROWS = kms_pkg::DefRows
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  kms_pkg::kms_in_t  item,
	output kms_pkg::kms_out_t result
);
	import kms_pkg::*;

	logic [ColW-1:0] row_q   [ROWS];
	logic [ColW-1:0] row_nxt [ROWS];
	logic [ROWS-1:0] scan_sel;
	logic [ROWS-1:0] rsi_sel;
	logic [ColW-1:0] scan_val;
	logic [ColW-1:0] rsi_val;
	logic            row_bad;

	// rows past the width of the output mask are never selected by a scan
	for (genvar r = 0; r < ROWS; r++) begin : g_sel
		if (r < MaskW) begin : g_m
			assign scan_sel[r] = item.out_mask[r];
		end else begin : g_n
			assign scan_sel[r] = 1'b0;
		end
		assign rsi_sel[r] = (r <= RsiLastRow);
	end

	always_comb begin
		scan_val = '0;
		rsi_val  = '0;
		for (int r = 0; r < ROWS; r++) begin
			scan_val = scan_val | (row_q[r] & {ColW{scan_sel[r]}});
			rsi_val  = rsi_val  | (row_q[r] & {ColW{rsi_sel[r]}});
		end
	end

	assign row_bad = !item.on_key && ({1'b0, item.row} >= (RowW+1)'(ROWS));

	always_comb begin
		result = '0;
		case (item.op)
			OP_SCAN: begin
				result.in_value = scan_val;
			end
			OP_IRQ_RST: begin
				result.irq_request = (rsi_val != '0) ? IRQ_MASKABLE : IRQ_NONE;
			end
			OP_PRESS: begin
				result.bad_row     = row_bad;
				result.irq_request = row_bad ? IRQ_NONE : IRQ_NMI;
			end
			OP_RELEASE: begin
				result.bad_row = row_bad;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	// each row decides its own next word; a bad row matches none of them
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			row_nxt[r] = row_q[r];
			case (item.op)
				OP_PRESS: begin
					if (item.on_key)
						row_nxt[r] = row_q[r] | OnBit;
					else if (item.row == RowW'(r))
						row_nxt[r] = row_q[r] | item.col_mask;
				end
				OP_RELEASE: begin
					if (item.on_key)
						row_nxt[r] = row_q[r] & OnClear;
					else if (item.row == RowW'(r))
						row_nxt[r] = row_q[r] & ~item.col_mask;
				end
				OP_CLEAR: begin
					row_nxt[r] = '0;
				end
				default: begin
					row_nxt[r] = row_q[r];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++)
				row_q[r] <= '0;
		end else if (fire) begin
			for (int r = 0; r < ROWS; r++)
				row_q[r] <= row_nxt[r];
		end
	end

endmodule

### rtl/core/keyboard_matrix_scanner_core.sv
// keyboard_matrix_scanner_core: top level of the keyboard matrix scanner
// input register, row file and result register; depends on kms_pkg, kms_row_file
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid/in_stall  | in_item  (kms_in_t)
//   out     | from block| out_valid/out_stall| out_item (kms_out_t)
//
// one transaction per cycle sustained while the result is not stalled; from input to result,
// an operation passes the input register and the result register around the row file
// the row words are read and updated in the same cycle an operation retires,
// so the next operation always sees the updated rows
// reset clears all row words and both valid flags
// a stalled result holds the input register, which then stalls the input
module keyboard_matrix_scanner_core #(
	parameter int ROWS = kms_pkg::DefRows
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  kms_pkg::kms_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output kms_pkg::kms_out_t out_item
);
	import kms_pkg::*;

	logic     valid_s1;
	kms_in_t  item_s1;
	logic     out_valid_q;
	kms_out_t out_q;
	kms_out_t result;
	logic     advance;
	logic     fire;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_item;
	end

	kms_row_file #(
		.ROWS(ROWS)
	) u_rows (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	a_retire: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("retired operation did not reach the result register");

	a_bad_row_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.bad_row) |->
		(out_q.irq_request == IRQ_NONE && out_q.in_value == '0))
		else $error("bad row result carries a value or an interrupt");

	a_irq_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.irq_request != 2'd3))
		else $error("interrupt request code out of range");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench of keyboard_matrix_scanner_core
// predicts every result from its own copy of the row words; depends on kms_pkg
module tb_top;
	import kms_pkg::*;

	localparam int Rows        = DefRows;
	localparam int MaxReported = 10;
	localparam int PhaseItems  = 313;

	class key_matrix_board;
		logic [ColW-1:0] row_words [MaxRows];
		kms_out_t        expected_q [$];
		int              errors;

		function new();
			errors = 0;
			foreach (row_words[r]) row_words[r] = '0;
		endfunction

		function logic [ColW-1:0] or_rows(logic [MaskW-1:0] sel);
			logic [ColW-1:0] acc;
			acc = '0;
			// mask bits for rows that do not exist add nothing
			for (int r = 0; r < Rows && r < MaskW; r++) begin
				if (sel[r]) acc |= row_words[r];
			end
			return acc;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MaxReported) $display("%0t: %s", $time, msg);
		endfunction

		function void note_input(kms_in_t it);
			kms_out_t         res;
			logic [MaskW-1:0] rsi_sel;
			res = '0;
			rsi_sel = '0;
			for (int r = 0; r <= RsiLastRow; r++) rsi_sel[r] = 1'b1;
			case (it.op)
				OP_SCAN: res.in_value = or_rows(it.out_mask);
				OP_IRQ_RST:
					res.irq_request = (or_rows(rsi_sel) != '0) ? IRQ_MASKABLE : IRQ_NONE;
				OP_PRESS: begin
					if (it.on_key) begin
						for (int r = 0; r < Rows; r++) row_words[r] |= OnBit;
						res.irq_request = IRQ_NMI;
					end else if (it.row >= Rows) begin
						res.bad_row = 1'b1;
					end else begin
						row_words[it.row] |= it.col_mask;
						res.irq_request = IRQ_NMI;
					end
				end
				OP_RELEASE: begin
					if (it.on_key) begin
						for (int r = 0; r < Rows; r++) row_words[r] &= OnClear;
					end else if (it.row >= Rows) begin
						res.bad_row = 1'b1;
					end else begin
						row_words[it.row] &= ~it.col_mask;
					end
				end
				OP_CLEAR: foreach (row_words[r]) row_words[r] = '0;
				default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		function void check_result(kms_out_t got);
			kms_out_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("result with nothing expected: value %h irq %0d bad %0b",
					got.in_value, got.irq_request, got.bad_row));
				return;
			end
			want = expected_q.pop_front();
			if (got.in_value !== want.in_value || got.irq_request !== want.irq_request ||
					got.bad_row !== want.bad_row)
				flag($sformatf({"mismatch: expected value %h irq %0d bad %0b, ",
					"got value %h irq %0d bad %0b"},
					want.in_value, want.irq_request, want.bad_row,
					got.in_value, got.irq_request, got.bad_row));
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	kms_in_t         in_item;
	logic            out_valid;
	logic            out_stall;
	kms_out_t        out_item;
	int              send_idle_pct;
	int              recv_stall_pct;
	key_matrix_board sb;

	keyboard_matrix_scanner_core #(
		.ROWS(Rows)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_item);
	end

	function automatic kms_in_t make_item(logic [2:0] op, logic [MaskW-1:0] sel,
			logic [RowW-1:0] row, logic [ColW-1:0] cols, logic on);
		kms_in_t it;
		it.op = op;
		it.out_mask = sel;
		it.row = row;
		it.col_mask = cols;
		it.on_key = on;
		return it;
	endfunction

	function automatic kms_in_t random_item();
		kms_in_t it;
		int      pick;
		pick = $urandom_range(99);
		it.out_mask = MaskW'($urandom);
		it.col_mask = ColW'($urandom);
		it.on_key = ($urandom_range(9) == 0);
		if ($urandom_range(9) == 0) it.row = RowW'($urandom_range(MaxRows - 1, Rows));
		else it.row = RowW'($urandom_range(Rows - 1));
		if (pick < 28) it.op = OP_SCAN;
		else if (pick < 38) it.op = OP_IRQ_RST;
		else if (pick < 64) it.op = OP_PRESS;
		else if (pick < 88) it.op = OP_RELEASE;
		else if (pick < 93) it.op = OP_CLEAR;
		else it.op = OP_CLEAR + 3'($urandom_range(3, 1));
		// single keys keep the row words sparse enough to be interesting
		if (it.op == OP_SCAN && $urandom_range(1))
			it.out_mask = MaskW'(1) << $urandom_range(MaskW - 1);
		if ((it.op == OP_PRESS && $urandom_range(1)) ||
				(it.op == OP_RELEASE && $urandom_range(9) < 7))
			it.col_mask = ColW'(1) << $urandom_range(ColW - 1);
		return it;
	endfunction

	// entered and left at a falling edge
	task automatic drive_item(kms_in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic run_phase(int idle, int stall, int count);
		kms_in_t it;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			it = random_item();
			drive_item(it);
		end
	endtask

	initial begin
		kms_in_t directed [$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed.push_back(make_item(OP_SCAN, 12'hFFF, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_IRQ_RST, 12'h000, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_PRESS, 12'h000, 4'd0, 16'hFFFF, 1'b0));
		directed.push_back(make_item(OP_SCAN, 12'h001, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_IRQ_RST, 12'hFFF, 4'd15, 16'hFFFF, 1'b1));
		directed.push_back(make_item(OP_RELEASE, 12'h000, 4'd0, 16'hFFFF, 1'b0));
		// a key in a row outside the interrupt-reset window makes the next interrupt reset raise nothing
		directed.push_back(make_item(OP_PRESS, 12'h000, 4'd11, 16'h0001, 1'b0));
		directed.push_back(make_item(OP_IRQ_RST, 12'h000, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_SCAN, 12'h800, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_PRESS, 12'h000, 4'd12, 16'hFFFF, 1'b0));
		directed.push_back(make_item(OP_RELEASE, 12'h000, 4'd15, 16'hFFFF, 1'b0));
		directed.push_back(make_item(OP_PRESS, 12'h000, 4'd5, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_PRESS, 12'h000, 4'd15, 16'hABCD, 1'b1));
		directed.push_back(make_item(OP_SCAN, 12'hFFF, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_IRQ_RST, 12'h000, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_RELEASE, 12'h000, 4'd13, 16'h5432, 1'b1));
		directed.push_back(make_item(OP_SCAN, 12'hFFF, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_CLEAR + 3'd1, 12'hFFF, 4'd15, 16'hFFFF, 1'b1));
		directed.push_back(make_item(OP_CLEAR + 3'd2, 12'hFFF, 4'd3, 16'hFFFF, 1'b0));
		directed.push_back(make_item(OP_CLEAR + 3'd3, 12'hFFF, 4'd7, 16'hFFFF, 1'b1));
		directed.push_back(make_item(OP_PRESS, 12'h000, 4'd8, 16'h1234, 1'b0));
		directed.push_back(make_item(OP_CLEAR, 12'hFFF, 4'd15, 16'hFFFF, 1'b1));
		directed.push_back(make_item(OP_SCAN, 12'hFFF, 4'd0, 16'h0000, 1'b0));
		directed.push_back(make_item(OP_RELEASE, 12'h000, 4'd3, 16'hFFFF, 1'b0));
		directed.push_back(make_item(OP_SCAN, 12'h000, 4'd0, 16'hFFFF, 1'b0));
		foreach (directed[i]) drive_item(directed[i]);

		// hold the sender off until the pipeline has emptied
		wait_drained();
		run_phase(0, 0, PhaseItems);
		wait_drained();
		run_phase(67, 0, PhaseItems);
		wait_drained();
		run_phase(0, 67, PhaseItems);
		wait_drained();
		run_phase(8, 8, PhaseItems);
		wait_drained();
		repeat (8) @(negedge clk);

		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
